### rtl/tefq_pkg.sv
package tefq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int ID_W    = 31;
    localparam int TIME_W  = 31;
    localparam int NOW_W   = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int CNT_O_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUBLISH = 2'd0,
        OP_POLL    = 2'd1,
        OP_PURGE   = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POLL,
        S_PURGE
    } state_t;

    // one stored message
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] pub_time;
        logic [TIME_W-1:0] life_time;
    } entry_t;

endpackage

### rtl/tefq_mem.sv
module tefq_mem #(
    parameter int DEPTH = tefq_pkg::DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  tefq_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output tefq_pkg::entry_t rd_data
);

    tefq_pkg::entry_t mem [DEPTH];
    tefq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/tefq_ctrl.sv
module tefq_ctrl #(
    parameter int DEPTH = tefq_pkg::DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tefq_pkg::OP_W-1:0]      op,
    input  logic [tefq_pkg::ID_W-1:0]      msg_id,
    input  logic [tefq_pkg::TIME_W-1:0]    publish_time,
    input  logic [tefq_pkg::TIME_W-1:0]    life_time,
    input  logic [tefq_pkg::NOW_W-1:0]     now_time,
    output logic                           done,
    output logic [tefq_pkg::STAT_W-1:0]    status,
    output logic [tefq_pkg::ID_W-1:0]      out_id,
    output logic [tefq_pkg::TIME_W-1:0]    out_publish_time,
    output logic [tefq_pkg::TIME_W-1:0]    out_life_time,
    output logic [tefq_pkg::CNT_O_W-1:0]   purged_count,
    output logic [tefq_pkg::CNT_O_W-1:0]   fill_level,
    output logic                           mem_wr_en,
    output logic [AW-1:0]                  mem_wr_addr,
    output tefq_pkg::entry_t               mem_wr_data,
    output logic                           mem_rd_en,
    output logic [AW-1:0]                  mem_rd_addr,
    input  tefq_pkg::entry_t               mem_rd_data
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    tefq_pkg::state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [CW-1:0] removed_reg, removed_next;
    logic [tefq_pkg::NOW_W-1:0] now_reg, now_next;
    logic rvalid_reg, rvalid_next;
    logic done_reg, done_next;

    logic [tefq_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [tefq_pkg::ID_W-1:0]    id_reg, id_next;
    logic [tefq_pkg::TIME_W-1:0]  pt_reg, pt_next;
    logic [tefq_pkg::TIME_W-1:0]  lt_reg, lt_next;
    logic [tefq_pkg::CNT_O_W-1:0] purged_reg, purged_next;
    logic [tefq_pkg::CNT_O_W-1:0] fill_reg, fill_next;

    logic accept;
    logic [tefq_pkg::NOW_W-1:0] expiry;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign busy   = (state_reg != tefq_pkg::S_IDLE);
    assign accept = start && !busy;
    // 31 + 31 bits never overflows 32
    assign expiry = tefq_pkg::NOW_W'(mem_rd_data.pub_time)
                  + tefq_pkg::NOW_W'(mem_rd_data.life_time);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tefq_pkg::S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            src_reg     <= '0;
            dst_reg     <= '0;
            left_reg    <= '0;
            kept_reg    <= '0;
            removed_reg <= '0;
            rvalid_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            left_reg    <= left_next;
            kept_reg    <= kept_next;
            removed_reg <= removed_next;
            rvalid_reg  <= rvalid_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        status_reg <= status_next;
        id_reg     <= id_next;
        pt_reg     <= pt_next;
        lt_reg     <= lt_next;
        purged_reg <= purged_next;
        fill_reg   <= fill_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        left_next    = left_reg;
        kept_next    = kept_reg;
        removed_next = removed_reg;
        rvalid_next  = 1'b0;
        now_next     = now_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        id_next      = id_reg;
        pt_next      = pt_reg;
        lt_next      = lt_reg;
        purged_next  = purged_reg;
        fill_next    = fill_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = tail_reg;
        mem_wr_data  = '{id: msg_id, pub_time: publish_time, life_time: life_time};
        mem_rd_en    = 1'b0;
        mem_rd_addr  = head_reg;

        case (state_reg)
            tefq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    status_next = tefq_pkg::ST_DONE;
                    id_next     = '0;
                    pt_next     = '0;
                    lt_next     = '0;
                    purged_next = '0;
                    fill_next   = tefq_pkg::CNT_O_W'(count_reg);
                    case (tefq_pkg::op_t'(op))
                        tefq_pkg::OP_PUBLISH:
                        begin
                            done_next = 1'b1;
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = tefq_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en  = 1'b1;
                                tail_next  = wrap_inc(tail_reg);
                                count_next = count_reg + 1'b1;
                                fill_next  = tefq_pkg::CNT_O_W'(count_reg + 1'b1);
                            end
                        end
                        tefq_pkg::OP_POLL:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = tefq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                head_next  = wrap_inc(head_reg);
                                count_next = count_reg - 1'b1;
                                state_next = tefq_pkg::S_POLL;
                            end
                        end
                        tefq_pkg::OP_PURGE:
                        begin
                            src_next     = head_reg;
                            dst_next     = head_reg;
                            left_next    = count_reg;
                            kept_next    = '0;
                            removed_next = '0;
                            now_next     = now_time;
                            state_next   = tefq_pkg::S_PURGE;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            tefq_pkg::S_POLL:
            begin
                done_next   = 1'b1;
                id_next     = mem_rd_data.id;
                pt_next     = mem_rd_data.pub_time;
                lt_next     = mem_rd_data.life_time;
                fill_next   = tefq_pkg::CNT_O_W'(count_reg);
                state_next  = tefq_pkg::S_IDLE;
            end

            tefq_pkg::S_PURGE:
            begin
                // read side runs one entry ahead of the compact/write side
                if (left_reg != '0)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = src_reg;
                    src_next    = wrap_inc(src_reg);
                    left_next   = left_reg - 1'b1;
                    rvalid_next = 1'b1;
                end
                if (rvalid_reg)
                begin
                    if (expiry <= now_reg)
                    begin
                        removed_next = removed_reg + 1'b1;
                    end
                    else
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = dst_reg;
                        mem_wr_data = mem_rd_data;
                        dst_next    = wrap_inc(dst_reg);
                        kept_next   = kept_reg + 1'b1;
                    end
                end
                if (left_reg == '0 && !rvalid_reg)
                begin
                    done_next   = 1'b1;
                    purged_next = tefq_pkg::CNT_O_W'(removed_reg);
                    fill_next   = tefq_pkg::CNT_O_W'(kept_reg);
                    count_next  = kept_reg;
                    tail_next   = dst_reg;
                    state_next  = tefq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tefq_pkg::S_IDLE;
            end
        endcase
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign out_id           = id_reg;
    assign out_publish_time = pt_reg;
    assign out_life_time    = lt_reg;
    assign purged_count     = purged_reg;
    assign fill_level       = fill_reg;

endmodule

### rtl/ttl_expiring_fifo_queue.sv
// Channel   Direction  Handshake                 Payload
// request   in         start && !busy            op, msg_id, publish_time, life_time, now_time
// result    out        done (one-cycle strobe)   status, out_id, out_publish_time,
//                                                out_life_time, purged_count, fill_level
//
// Publish and no-op answer in the cycle after acceptance and leave busy low.
// Poll answers after one synchronous memory read in S_POLL. Purge stays in S_PURGE
// until every held entry has been read and checked: the entry memory is scanned one
// entry a cycle through its single read port.
// Reset clears pointers, count and state; the entry memory needs no clearing.
// The receiver cannot stall: every result is shown once for one cycle.
module ttl_expiring_fifo_queue #(
    parameter int DEPTH = tefq_pkg::DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tefq_pkg::OP_W-1:0]      op,
    input  logic [tefq_pkg::ID_W-1:0]      msg_id,
    input  logic [tefq_pkg::TIME_W-1:0]    publish_time,
    input  logic [tefq_pkg::TIME_W-1:0]    life_time,
    input  logic [tefq_pkg::NOW_W-1:0]     now_time,
    output logic                           done,
    output logic [tefq_pkg::STAT_W-1:0]    status,
    output logic [tefq_pkg::ID_W-1:0]      out_id,
    output logic [tefq_pkg::TIME_W-1:0]    out_publish_time,
    output logic [tefq_pkg::TIME_W-1:0]    out_life_time,
    output logic [tefq_pkg::CNT_O_W-1:0]   purged_count,
    output logic [tefq_pkg::CNT_O_W-1:0]   fill_level
);

    // memory port signals between sequencer and entry store
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    tefq_pkg::entry_t mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    tefq_pkg::entry_t mem_rd_data;

    // sequencer: pointers, count, request decode and the purge compaction scan
    tefq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .msg_id           (msg_id),
        .publish_time     (publish_time),
        .life_time        (life_time),
        .now_time         (now_time),
        .done             (done),
        .status           (status),
        .out_id           (out_id),
        .out_publish_time (out_publish_time),
        .out_life_time    (out_life_time),
        .purged_count     (purged_count),
        .fill_level       (fill_level),
        .mem_wr_en        (mem_wr_en),
        .mem_wr_addr      (mem_wr_addr),
        .mem_wr_data      (mem_wr_data),
        .mem_rd_en        (mem_rd_en),
        .mem_rd_addr      (mem_rd_addr),
        .mem_rd_data      (mem_rd_data)
    );

    // entry store: one write port, one registered read port
    tefq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // publish and no-op transactions answer on the very next cycle
    a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == tefq_pkg::OP_PUBLISH || op == tefq_pkg::OP_NOP))
        |=> done)
        else $error("publish/no-op result missing");

    // a refused publish only happens with the store full
    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == tefq_pkg::ST_FULL) |-> (fill_level == tefq_pkg::CNT_O_W'(DEPTH)))
        else $error("full status with store not full");

    // an empty poll reports an empty store and no data
    a_empty_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == tefq_pkg::ST_EMPTY) |-> (fill_level == '0 && out_id == '0))
        else $error("empty status inconsistent");

    // only a purge may report removals, and that never with an error status
    a_purge_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != tefq_pkg::ST_DONE) |-> (purged_count == '0))
        else $error("removal count on error status");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import tefq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int IDLE_PCT    = 26;
    localparam int N_RANDOM    = 1000;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 40;

    localparam logic [TIME_W-1:0] T_MAX   = '1;
    localparam logic [ID_W-1:0]   ID_MAX  = '1;
    localparam logic [NOW_W-1:0]  NOW_MAX = '1;

    // One request transaction as the sender holds it.
    typedef struct {
        op_t               op;
        logic [ID_W-1:0]   msg_id;
        logic [TIME_W-1:0] pub_time;
        logic [TIME_W-1:0] life_time;
        logic [NOW_W-1:0]  now_time;
        bit                may_idle;     // sender may insert random gaps before it
        bit                drain_first;  // hold off until every answer is back
    } request_t;

    // One answer transaction, field for field as on the result ports.
    typedef struct packed {
        status_t             status;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   pub_time;
        logic [TIME_W-1:0]   life_time;
        logic [CNT_O_W-1:0]  purged;
        logic [CNT_O_W-1:0]  fill;
    } answer_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                start        = 1'b0;
    logic [OP_W-1:0]     op           = '0;
    logic [ID_W-1:0]     msg_id       = '0;
    logic [TIME_W-1:0]   publish_time = '0;
    logic [TIME_W-1:0]   life_time    = '0;
    logic [NOW_W-1:0]    now_time     = '0;

    logic                busy;
    logic                done;
    logic [STAT_W-1:0]   status;
    logic [ID_W-1:0]     out_id;
    logic [TIME_W-1:0]   out_publish_time;
    logic [TIME_W-1:0]   out_life_time;
    logic [CNT_O_W-1:0]  purged_count;
    logic [CNT_O_W-1:0]  fill_level;

    request_t    pending_reqs[$];   // requests still to be sent
    answer_t     due_answers[$];    // predicted answers, oldest first
    entry_t      held_msgs[$];      // predicted queue contents, head first

    request_t    cur;
    bit          have_cur   = 1'b0;
    int unsigned n_accepted = 0;
    int unsigned n_results  = 0;
    int unsigned n_errors   = 0;
    int unsigned n_cycles   = 0;

    ttl_expiring_fifo_queue #(
        .DEPTH (DEPTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .msg_id           (msg_id),
        .publish_time     (publish_time),
        .life_time        (life_time),
        .now_time         (now_time),
        .done             (done),
        .status           (status),
        .out_id           (out_id),
        .out_publish_time (out_publish_time),
        .out_life_time    (out_life_time),
        .purged_count     (purged_count),
        .fill_level       (fill_level)
    );

    always #4 clk = ~clk;

    // Applies one accepted request to the predicted queue and returns the answer.
    // Purge keeps survivors in order; the expiry sum is taken at 33 bits so it
    // can never wrap.
    function automatic answer_t apply_request(input request_t rq);
        answer_t      ans;
        entry_t       msg;
        entry_t       kept[$];
        logic [32:0]  expiry;
        int unsigned  n_gone;
        ans    = '0;
        n_gone = 0;
        case (rq.op)
            OP_PUBLISH:
            begin
                if (held_msgs.size() >= DEPTH)
                begin
                    ans.status = ST_FULL;
                end
                else
                begin
                    msg.id        = rq.msg_id;
                    msg.pub_time  = rq.pub_time;
                    msg.life_time = rq.life_time;
                    held_msgs.insert(held_msgs.size(), msg);
                end
            end
            OP_POLL:
            begin
                if (held_msgs.size() == 0)
                begin
                    ans.status = ST_EMPTY;
                end
                else
                begin
                    msg           = held_msgs.pop_front();
                    ans.id        = msg.id;
                    ans.pub_time  = msg.pub_time;
                    ans.life_time = msg.life_time;
                end
            end
            OP_PURGE:
            begin
                foreach (held_msgs[k])
                begin
                    expiry = {2'b00, held_msgs[k].pub_time} + {2'b00, held_msgs[k].life_time};
                    if (expiry <= {1'b0, rq.now_time})
                        n_gone++;
                    else
                        kept.insert(kept.size(), held_msgs[k]);
                end
                held_msgs  = kept;
                ans.purged = CNT_O_W'(n_gone);
            end
            default:
            begin
                // no-op: nothing changes, only the fill level is reported
            end
        endcase
        ans.fill = CNT_O_W'(held_msgs.size());
        return ans;
    endfunction

    function automatic request_t make_req(input op_t kind, input logic [ID_W-1:0] id,
                                          input logic [TIME_W-1:0] pt,
                                          input logic [TIME_W-1:0] lt,
                                          input logic [NOW_W-1:0] now);
        request_t rq;
        rq.op          = kind;
        rq.msg_id      = id;
        rq.pub_time    = pt;
        rq.life_time   = lt;
        rq.now_time    = now;
        rq.may_idle    = 1'b1;
        rq.drain_first = 1'b0;
        return rq;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result %0d: %s got %0h expected %0h", $time, n_results, what, got, want);
        n_errors++;
    endtask

    // Driver: presents the head of pending_reqs and holds it until start && !busy
    // takes it at an edge. The prediction is made at that same edge, so answers
    // queue up in acceptance order. While idle, the data ports carry noise.
    always @(posedge clk or negedge rst_n)
    begin : driver
        int unsigned in_flight;
        bit          go;
        if (!rst_n)
        begin
            start        <= 1'b0;
            op           <= '0;
            msg_id       <= '0;
            publish_time <= '0;
            life_time    <= '0;
            now_time     <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                due_answers.insert(due_answers.size(), apply_request(cur));
                n_accepted++;
                have_cur = 1'b0;
            end
            if (!have_cur && pending_reqs.size() != 0)
            begin
                cur      = pending_reqs.pop_front();
                have_cur = 1'b1;
            end
            // n_results is updated by the monitor with a nonblocking write, so the
            // value seen here excludes any answer strobed at this edge: take it off.
            in_flight = n_accepted - n_results - ((done === 1'b1) ? 1 : 0);
            go = have_cur;
            if (go && cur.drain_first && in_flight != 0)
                go = 1'b0;
            if (go && cur.may_idle && $urandom_range(0, 99) < IDLE_PCT)
                go = 1'b0;
            start <= go;
            if (go)
            begin
                op           <= cur.op;
                msg_id       <= cur.msg_id;
                publish_time <= cur.pub_time;
                life_time    <= cur.life_time;
                now_time     <= cur.now_time;
            end
            else
            begin
                op           <= OP_W'($urandom_range(0, 3));
                msg_id       <= ID_W'($urandom);
                publish_time <= TIME_W'($urandom);
                life_time    <= TIME_W'($urandom);
                now_time     <= $urandom;
            end
        end
    end

    // Monitor: every strobed answer must match the oldest prediction.
    always @(posedge clk)
    begin : monitor
        answer_t want;
        if (rst_n && done === 1'b1)
        begin
            n_results <= n_results + 1;
            if (due_answers.size() == 0)
            begin
                report_mismatch("answer with no transaction outstanding, status", status, '0);
            end
            else
            begin
                want = due_answers.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (out_id !== want.id)
                    report_mismatch("out_id", out_id, want.id);
                if (out_publish_time !== want.pub_time)
                    report_mismatch("out_publish_time", out_publish_time, want.pub_time);
                if (out_life_time !== want.life_time)
                    report_mismatch("out_life_time", out_life_time, want.life_time);
                if (purged_count !== want.purged)
                    report_mismatch("purged_count", purged_count, want.purged);
                if (fill_level !== want.fill)
                    report_mismatch("fill_level", fill_level, want.fill);
            end
        end
    end

    // Watchdog against a hang.
    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT)
        begin
            $display("ttl_expiring_fifo_queue regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        request_t          rq;
        logic [TIME_W-1:0] pt;
        logic [TIME_W-1:0] lt;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] sim_now;
        logic [NOW_W-1:0]  now;
        int unsigned       pub_bias;
        int unsigned       r;

        // Directed: empty poll, no-op and purge on an empty queue, then fill to
        // DEPTH with extreme field values (zero expiry mid-queue, maximum sum),
        // a refused publish, and purges right on the expiry boundaries.
        pending_reqs.insert(pending_reqs.size(), make_req(OP_POLL, '0, '0, '0, '0));
        pending_reqs.insert(pending_reqs.size(),
                            make_req(OP_NOP, ID_MAX, T_MAX, T_MAX, NOW_MAX));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_PURGE, '0, '0, '0, '0));
        for (int k = 0; k < DEPTH; k++)
        begin
            id = ID_W'($urandom);
            pt = TIME_W'($urandom_range(1000, 100000));
            lt = TIME_W'($urandom_range(1, 1000));
            case (k)
                1:
                begin
                    id = ID_MAX;
                    pt = T_MAX;
                    lt = T_MAX;
                end
                2:
                begin
                    pt = T_MAX;
                    lt = '0;
                end
                3:
                begin
                    pt = '0;
                    lt = T_MAX;
                end
                5:
                begin
                    id = '0;
                    pt = '0;
                    lt = '0;
                end
                default:
                begin
                end
            endcase
            pending_reqs.insert(pending_reqs.size(),
                                make_req(OP_PUBLISH, id, pt, lt, NOW_W'($urandom)));
        end
        pending_reqs.insert(pending_reqs.size(),
                            make_req(OP_PUBLISH, ID_MAX, T_MAX, T_MAX, NOW_MAX));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_NOP, '0, '0, '0, '0));
        pending_reqs.insert(pending_reqs.size(),
                            make_req(OP_PURGE, ID_MAX, T_MAX, T_MAX, '0));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_POLL, '0, '0, '0, '0));
        pending_reqs.insert(pending_reqs.size(),
                            make_req(OP_PURGE, '0, '0, '0, 32'h7FFF_FFFF));
        pending_reqs.insert(pending_reqs.size(),
                            make_req(OP_PURGE, '0, '0, '0, 32'hFFFF_FFFE));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_POLL, '0, '0, '0, '0));

        // Random: a moving time base keeps publish times and purge times close
        // enough that purges remove some but not all. Each block of 200 has its
        // own publish weight so the queue both fills up and runs dry.
        sim_now  = '0;
        pub_bias = 50;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 200 == 0)
            begin
                sim_now  = TIME_W'($urandom_range(0, 32'h7FFF_E000));
                pub_bias = $urandom_range(30, 80);
            end
            sim_now = sim_now + TIME_W'($urandom_range(0, 20));
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                // noise: any op, any field content
                rq = make_req(op_t'($urandom_range(0, 3)), ID_W'($urandom),
                              TIME_W'($urandom), TIME_W'($urandom), $urandom);
            end
            else if (r < 8)
            begin
                rq = make_req(OP_NOP, ID_W'($urandom), TIME_W'($urandom),
                              TIME_W'($urandom), $urandom);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < pub_bias)
                begin
                    pt = (sim_now > 50) ? sim_now - TIME_W'($urandom_range(0, 50)) : sim_now;
                    lt = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                                     : TIME_W'($urandom_range(0, 300));
                    rq = make_req(OP_PUBLISH, ID_W'($urandom), pt, lt, $urandom);
                end
                else if (r < pub_bias + (100 - pub_bias) / 2)
                begin
                    rq = make_req(OP_POLL, ID_W'($urandom), TIME_W'($urandom),
                                  TIME_W'($urandom), $urandom);
                end
                else
                begin
                    now = ($urandom_range(0, 9) == 0) ? NOW_W'($urandom)
                          : {1'b0, sim_now} + NOW_W'($urandom_range(0, 300));
                    rq = make_req(OP_PURGE, ID_W'($urandom), TIME_W'($urandom),
                                  TIME_W'($urandom), now);
                end
            end
            // long burst with no random sender gaps
            if (i >= 400 && i < 600)
                rq.may_idle = 1'b0;
            // sender waits for every outstanding answer now and then
            if (i % 250 == 0)
                rq.drain_first = 1'b1;
            pending_reqs.insert(pending_reqs.size(), rq);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled on the falling edge, clear of the driver and monitor updates.
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || have_cur || due_answers.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (n_errors == 0)
            $display("ttl_expiring_fifo_queue regression: pass");
        else
            $display("ttl_expiring_fifo_queue regression: fail");
        $finish;
    end

endmodule
